// ===== sv/idl_pkg.sv =====
package idl_pkg;

	// Fixed field widths of the request and result transactions.
	localparam int POS_W  = 6;
	localparam int DATA_W = 32;
	localparam int LEN_W  = 7;

	// Request kinds.
	localparam logic [2:0] KIND_PUSH_BACK  = 3'd0;
	localparam logic [2:0] KIND_POP_BACK   = 3'd1;
	localparam logic [2:0] KIND_PUSH_FRONT = 3'd2;
	localparam logic [2:0] KIND_POP_FRONT  = 3'd3;
	localparam logic [2:0] KIND_REPLACE    = 3'd4;
	localparam logic [2:0] KIND_INSERT     = 3'd5;
	localparam logic [2:0] KIND_DELETE     = 3'd6;
	localparam logic [2:0] KIND_SORT       = 3'd7;

	// Result status codes.
	localparam logic [1:0] STAT_OK    = 2'd0;
	localparam logic [1:0] STAT_EMPTY = 2'd1;
	localparam logic [1:0] STAT_FULL  = 2'd2;
	localparam logic [1:0] STAT_RANGE = 2'd3;

	// Commands broadcast to every cell of the chain.
	localparam logic [2:0] CMD_NONE   = 3'd0;
	localparam logic [2:0] CMD_INSERT = 3'd1;
	localparam logic [2:0] CMD_REMOVE = 3'd2;
	localparam logic [2:0] CMD_WRITE  = 3'd3;
	localparam logic [2:0] CMD_SORT   = 3'd4;

	// Control bundle shared by all cells in a cycle.
	typedef struct packed {
		logic [2:0]               cmd;
		logic                     phase;
		logic signed [DATA_W-1:0] value;
	} cell_ctl_t;

endpackage

// ===== sv/indexed_deque_list_engine.sv =====
// Bounded ordered list of signed 32-bit values held in a chain of CAPACITY cells, element 0
// at the front. Push, pop front, insert and delete shift values between neighboring cells,
// all cells at once; replace writes one cell and pop back only shortens the list. Each such
// transaction's result is registered in the cycle after it is accepted. A sort runs
// odd-even transposition along the chain, one phase per cycle: on a list of two or more
// elements it holds off new requests until the sort is done, then returns its result; a
// shorter list returns at once. Every request returns exactly one result transaction with
// the removed value (pop only), a status code and the new length. The list contents are
// undefined after reset, but only entries that have been written are ever returned.
module indexed_deque_list_engine #(
	parameter int CAPACITY = 64
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic [2:0]                        kind,
	input  logic [idl_pkg::POS_W-1:0]         position,
	input  logic signed [idl_pkg::DATA_W-1:0] value,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic signed [idl_pkg::DATA_W-1:0] data,
	output logic                              data_valid,
	output logic [1:0]                        status,
	output logic [idl_pkg::LEN_W-1:0]         length
);

	localparam int CNT_W = $clog2(CAPACITY + 1);
	localparam int IDX_W = $clog2(CAPACITY);
	localparam int CMP_W = (CNT_W > idl_pkg::POS_W) ? CNT_W : idl_pkg::POS_W;
	localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

	localparam logic ST_IDLE = 1'b0;
	localparam logic ST_SORT = 1'b1;

	logic                              state_q;
	logic [CNT_W-1:0]                  count_q;
	logic [CNT_W-1:0]                  pass_q;
	logic                              phase_q;
	logic                              out_valid_q;
	logic signed [idl_pkg::DATA_W-1:0] data_q;
	logic                              data_valid_q;
	logic [1:0]                        status_q;
	logic [idl_pkg::LEN_W-1:0]         length_q;

	logic                              accept;
	logic                              sort_done;
	logic [CMP_W-1:0]                  pos_ext;
	logic [CMP_W-1:0]                  cnt_ext;
	logic [CNT_W-1:0]                  cnt_m1;
	logic [2:0]                        req_cmd;
	logic [CNT_W-1:0]                  req_pos;
	logic [CNT_W-1:0]                  cnt_nxt;
	logic [1:0]                        req_status;
	logic signed [idl_pkg::DATA_W-1:0] req_data;
	logic                              req_data_valid;
	logic                              go_sort;
	idl_pkg::cell_ctl_t                ctl;

	logic signed [idl_pkg::DATA_W-1:0] vals    [CAPACITY];
	logic                              lts     [CAPACITY];
	logic signed [idl_pkg::DATA_W-1:0] left_v  [CAPACITY];
	logic signed [idl_pkg::DATA_W-1:0] right_v [CAPACITY];
	logic                              right_lt[CAPACITY];

	// Handshake: a new transaction waits while sorting or while a result is stuck.
	assign in_stall  = (state_q == ST_SORT) || (out_valid_q && out_stall);
	assign accept    = in_valid && !in_stall;
	assign sort_done = (state_q == ST_SORT) && (pass_q == cnt_m1);

	assign out_valid  = out_valid_q;
	assign data       = data_q;
	assign data_valid = data_valid_q;
	assign status     = status_q;
	assign length     = length_q;

	assign pos_ext = CMP_W'(position);
	assign cnt_ext = CMP_W'(count_q);
	assign cnt_m1  = count_q - CNT_W'(1);

	// Request decode: checks, the command for the cells and the result fields.
	always_comb begin
		req_cmd        = idl_pkg::CMD_NONE;
		req_pos        = '0;
		cnt_nxt        = count_q;
		req_status     = idl_pkg::STAT_OK;
		req_data       = '0;
		req_data_valid = 1'b0;
		go_sort        = 1'b0;
		case (kind)
			idl_pkg::KIND_PUSH_BACK, idl_pkg::KIND_PUSH_FRONT: begin
				if (count_q == CAP_CNT) begin
					req_status = idl_pkg::STAT_FULL;
				end else begin
					req_cmd = idl_pkg::CMD_INSERT;
					req_pos = (kind == idl_pkg::KIND_PUSH_BACK) ? count_q : '0;
					cnt_nxt = count_q + CNT_W'(1);
				end
			end
			idl_pkg::KIND_POP_BACK: begin
				if (count_q == '0) begin
					req_status = idl_pkg::STAT_EMPTY;
				end else begin
					req_data       = vals[cnt_m1[IDX_W-1:0]];
					req_data_valid = 1'b1;
					cnt_nxt        = cnt_m1;
				end
			end
			idl_pkg::KIND_POP_FRONT: begin
				if (count_q == '0) begin
					req_status = idl_pkg::STAT_EMPTY;
				end else begin
					req_data       = vals[0];
					req_data_valid = 1'b1;
					req_cmd        = idl_pkg::CMD_REMOVE;
					cnt_nxt        = cnt_m1;
				end
			end
			idl_pkg::KIND_REPLACE: begin
				if (pos_ext >= cnt_ext) begin
					req_status = idl_pkg::STAT_RANGE;
				end else begin
					req_cmd = idl_pkg::CMD_WRITE;
					req_pos = pos_ext[CNT_W-1:0];
				end
			end
			idl_pkg::KIND_INSERT: begin
				if (pos_ext > cnt_ext) begin
					req_status = idl_pkg::STAT_RANGE;
				end else if (count_q == CAP_CNT) begin
					req_status = idl_pkg::STAT_FULL;
				end else begin
					req_cmd = idl_pkg::CMD_INSERT;
					req_pos = pos_ext[CNT_W-1:0];
					cnt_nxt = count_q + CNT_W'(1);
				end
			end
			idl_pkg::KIND_DELETE: begin
				if (count_q == '0) begin
					req_status = idl_pkg::STAT_EMPTY;
				end else if (pos_ext >= cnt_ext) begin
					req_status = idl_pkg::STAT_RANGE;
				end else begin
					req_cmd = idl_pkg::CMD_REMOVE;
					req_pos = pos_ext[CNT_W-1:0];
					cnt_nxt = cnt_m1;
				end
			end
			default: begin
				go_sort = (count_q > CNT_W'(1));
			end
		endcase
	end

	// Broadcast control for the chain.
	always_comb begin
		ctl.value = value;
		ctl.phase = phase_q;
		if (accept) begin
			ctl.cmd = req_cmd;
		end else if (state_q == ST_SORT) begin
			ctl.cmd = idl_pkg::CMD_SORT;
		end else begin
			ctl.cmd = idl_pkg::CMD_NONE;
		end
	end

	// The chain of cells with neighbor links; the ends see empty neighbors.
	for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
		if (g == 0) begin : g_first
			assign left_v[g] = '0;
		end else begin : g_left
			assign left_v[g] = vals[g-1];
		end
		if (g == CAPACITY - 1) begin : g_last
			assign right_v[g]  = '0;
			assign right_lt[g] = 1'b0;
		end else begin : g_right
			assign right_v[g]  = vals[g+1];
			assign right_lt[g] = lts[g+1];
		end

		idl_cell #(
			.CAPACITY (CAPACITY),
			.INDEX    (g)
		) u_cell (
			.clk           (clk),
			.ctl           (ctl),
			.pos           (req_pos),
			.count         (count_q),
			.left_val      (left_v[g]),
			.right_val     (right_v[g]),
			.right_lt_left (right_lt[g]),
			.val           (vals[g]),
			.lt_left       (lts[g])
		);
	end

	// Control state: list length, sort sequencing and result valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			count_q     <= '0;
			pass_q      <= '0;
			phase_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			// A new result sets the valid flag; a taken result clears it.
			if ((accept && !go_sort) || sort_done) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						count_q <= cnt_nxt;
						pass_q  <= '0;
						phase_q <= 1'b0;
						if (go_sort) begin
							state_q <= ST_SORT;
						end
					end
				end
				ST_SORT: begin
					pass_q  <= pass_q + CNT_W'(1);
					phase_q <= !phase_q;
					if (sort_done) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Result payload register.
	always_ff @(posedge clk) begin
		if (accept && !go_sort) begin
			data_q       <= req_data;
			data_valid_q <= req_data_valid;
			status_q     <= req_status;
			length_q     <= idl_pkg::LEN_W'(cnt_nxt);
		end else if (sort_done) begin
			data_q       <= '0;
			data_valid_q <= 1'b0;
			status_q     <= idl_pkg::STAT_OK;
			length_q     <= idl_pkg::LEN_W'(count_q);
		end
	end

endmodule

// ===== sv/idl_cell.sv =====
module idl_cell #(
	parameter int CAPACITY = 64,
	parameter int INDEX    = 0
) (
	input  logic                             clk,
	input  idl_pkg::cell_ctl_t               ctl,
	input  logic [$clog2(CAPACITY+1)-1:0]    pos,
	input  logic [$clog2(CAPACITY+1)-1:0]    count,
	input  logic signed [idl_pkg::DATA_W-1:0] left_val,
	input  logic signed [idl_pkg::DATA_W-1:0] right_val,
	input  logic                             right_lt_left,
	output logic signed [idl_pkg::DATA_W-1:0] val,
	output logic                             lt_left
);

	localparam int CNT_W = $clog2(CAPACITY + 1);
	localparam logic [CNT_W-1:0] IDX    = CNT_W'(INDEX);
	localparam logic [CNT_W-1:0] IDX_P1 = CNT_W'(INDEX + 1);
	localparam logic             IDX_ODD = 1'(INDEX % 2);
	localparam logic             HAS_LEFT = (INDEX != 0);

	logic signed [idl_pkg::DATA_W-1:0] val_q;
	logic signed [idl_pkg::DATA_W-1:0] val_nxt;
	logic                              take_left;
	logic                              take_right;

	assign val     = val_q;
	assign lt_left = (val_q < left_val);

	// Compare-exchange with a neighbor during an odd-even sort phase. The pair
	// below this cell is active when its lower index matches the phase, the
	// pair above when this index matches; only pairs inside the list count.
	always_comb begin
		take_left  = HAS_LEFT && (IDX_ODD != ctl.phase) && (IDX < count) && lt_left;
		take_right = (IDX_ODD == ctl.phase) && (IDX_P1 < count) && right_lt_left;
	end

	// Next value of the cell for the broadcast command.
	always_comb begin
		val_nxt = val_q;
		case (ctl.cmd)
			idl_pkg::CMD_INSERT: begin
				if (IDX > pos) begin
					val_nxt = left_val;
				end else if (IDX == pos) begin
					val_nxt = ctl.value;
				end
			end
			idl_pkg::CMD_REMOVE: begin
				if (IDX >= pos) begin
					val_nxt = right_val;
				end
			end
			idl_pkg::CMD_WRITE: begin
				if (IDX == pos) begin
					val_nxt = ctl.value;
				end
			end
			idl_pkg::CMD_SORT: begin
				if (take_left) begin
					val_nxt = left_val;
				end else if (take_right) begin
					val_nxt = right_val;
				end
			end
			default: begin
				val_nxt = val_q;
			end
		endcase
	end

	// Element storage needs no reset: only written entries are ever read.
	always_ff @(posedge clk) begin
		val_q <= val_nxt;
	end

endmodule
